[sv/fsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, constants and arithmetic helpers of the palette dither block.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int MaxWidthDef     = 2048;
  localparam int PaletteDepthDef = 256;
  localparam int CfgW            = 12;
  localparam int ErrW            = 10;
  localparam int HalfW           = 3 * ErrW;
  localparam int WordW           = 2 * HalfW;
  localparam int DistW           = 19;

  typedef enum logic {
    CFG_IMAGE_WIDTH   = 1'b0,
    CFG_PALETTE_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } item_cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       row_end;
  } pix_out_t;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD0   = 13'b0000000000100,
    S_RD1   = 13'b0000000001000,
    S_RD2   = 13'b0000000010000,
    S_RD3   = 13'b0000000100000,
    S_SRCH  = 13'b0000001000000,
    S_DRAIN = 13'b0000010000000,
    S_ERR   = 13'b0000100000000,
    S_WR0   = 13'b0001000000000,
    S_WR1   = 13'b0010000000000,
    S_WR2   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic take;
    logic rd_x;
    logic rd_xm;
    logic rd_xp;
    logic cap_x;
    logic cap_xm;
    logic cap_xp;
    logic srch_start;
    logic srch_step;
    logic calc_err;
    logic wr_xm;
    logic wr_x;
    logic wr_xp;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic srch_last;
    logic out_free;
  } dp_stat_t;

  // Signed divide by 16 with truncation toward zero.
  function automatic logic signed [ErrW-1:0] div16(input logic signed [12:0] v);
    logic signed [12:0] t;
    t = v + (v < 0 ? 13'sd15 : 13'sd0);
    return ErrW'(t >>> 4);
  endfunction

  function automatic logic signed [12:0] mulk(input logic signed [ErrW-1:0] e,
                                              input logic signed [12:0] k);
    return 13'(13'(e) * k);
  endfunction

  function automatic logic [DistW-1:0] dist_sq(input logic [23:0] c,
                                               input logic [23:0] p);
    logic [DistW-1:0] d;
    logic signed [8:0] df;
    logic signed [17:0] sq;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      df = $signed({1'b0, c[k*8 +: 8]}) - $signed({1'b0, p[k*8 +: 8]});
      sq = df * df;
      d = d + DistW'(sq[16:0]);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[sv/fsd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_ctrl
// Sequencer: clear pass, error reads, palette search, error write-back, emit.
// ----------------------------------------------------------------------------
module fsd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  fsd_pkg::pix_in_t in_data_i,
  output logic            in_stall_o,
  input  fsd_pkg::dp_stat_t stat_i,
  output fsd_pkg::dp_cmd_t  cmd_o
);
  import fsd_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) begin
          state_d = pend_q ? S_RD0 : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (acc) begin
          cmd_o.take = 1'b1;
          if (in_data_i.command == CMD_PIXEL) begin
            if (in_data_i.frame_start) begin
              state_d = S_CLEAR;
              pend_d  = 1'b1;
            end else begin
              state_d = S_RD0;
            end
          end
        end
      end
      S_RD0: begin
        cmd_o.rd_x = 1'b1;
        state_d    = S_RD1;
      end
      S_RD1: begin
        cmd_o.cap_x = 1'b1;
        cmd_o.rd_xm = 1'b1;
        state_d     = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_xm = 1'b1;
        cmd_o.rd_xp  = 1'b1;
        state_d      = S_RD3;
      end
      S_RD3: begin
        cmd_o.cap_xp     = 1'b1;
        cmd_o.srch_start = 1'b1;
        state_d          = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (stat_i.srch_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_ERR;
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_WR0;
      end
      S_WR0: begin
        cmd_o.wr_xm = 1'b1;
        state_d     = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr_x = 1'b1;
        state_d    = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr_xp = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

[sv/fsd_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsd_dp
// Datapath: palette and error-row memories, distance unit, error diffusion.
// ----------------------------------------------------------------------------
module fsd_dp #(
  parameter int MAX_WIDTH     = fsd_pkg::MaxWidthDef,
  parameter int PALETTE_DEPTH = fsd_pkg::PaletteDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [fsd_pkg::CfgW-1:0]  cfg_data_i,
  input  fsd_pkg::pix_in_t          in_data_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output fsd_pkg::pix_out_t         out_data_o,
  input  fsd_pkg::dp_cmd_t          cmd_i,
  output fsd_pkg::dp_stat_t         stat_o
);
  import fsd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PA = $clog2(PALETTE_DEPTH);
  localparam int NW = $clog2(PALETTE_DEPTH + 1);

  logic [WordW-1:0] emem [MAX_WIDTH];
  logic [23:0]      pmem [PALETTE_DEPTH];

  logic [11:0]      width_q;
  logic [8:0]       pcnt_q;
  logic [WW-1:0]    w_eff;
  logic [NW-1:0]    n_eff;
  logic [CW-1:0]    col_q, clr_q, raddr, waddr;
  logic             rsel_q, rsel_n, last, re, we;
  logic [WordW-1:0] erd_q, wx_q, wxm_q, wxp_q, wdata;
  logic [23:0]      pix_q, c_q, prd_q, bestrgb_q;
  logic [PA-1:0]    sa_q, pi_q, best_q;
  logic             pv_q, pal_we;
  logic [DistW-1:0] bestd_q, dcur;
  logic signed [ErrW-1:0] e_q [3];
  logic             out_valid_q;
  pix_out_t         out_q;

  always_comb begin
    if (width_q == '0)                    w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH)    w_eff = WW'(MAX_WIDTH);
    else                                  w_eff = WW'(width_q);
    if (pcnt_q == '0)                     n_eff = NW'(1);
    else if (32'(pcnt_q) > PALETTE_DEPTH) n_eff = NW'(PALETTE_DEPTH);
    else                                  n_eff = NW'(pcnt_q);
  end

  assign last   = (WW'(col_q) + WW'(1)) >= w_eff;
  assign rsel_n = ~rsel_q;

  assign stat_o.clr_done  = (clr_q == CW'(MAX_WIDTH - 1));
  assign stat_o.srch_last = (NW'(sa_q) + NW'(1)) == n_eff;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd1;
      pcnt_q  <= 9'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) width_q <= cfg_data_i;
      else                                pcnt_q  <= cfg_data_i[8:0];
    end
  end

  // error-row memory read port selection
  always_comb begin
    re    = cmd_i.rd_x || cmd_i.rd_xm || cmd_i.rd_xp;
    raddr = col_q;
    if (cmd_i.rd_xm) raddr = col_q - CW'(1);
    if (cmd_i.rd_xp) raddr = col_q + CW'(1);
  end

  always_comb begin
    logic [HalfW-1:0] cur_h, nxt_h;
    logic [WordW-1:0] w;
    we    = 1'b0;
    waddr = col_q;
    wdata = '0;
    w     = '0;
    cur_h = '0;
    nxt_h = '0;
    if (cmd_i.clr_en) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.wr_xm) begin
      we    = (col_q != '0);
      waddr = col_q - CW'(1);
      w     = wxm_q;
      nxt_h = w[rsel_n*HalfW +: HalfW];
      for (int k = 0; k < 3; k++)
        nxt_h[k*ErrW +: ErrW] = nxt_h[k*ErrW +: ErrW] + div16(mulk(e_q[k], 13'sd3));
      w[rsel_n*HalfW +: HalfW] = nxt_h;
      wdata = w;
    end else if (cmd_i.wr_x) begin
      we    = 1'b1;
      w     = wx_q;
      nxt_h = w[rsel_n*HalfW +: HalfW];
      for (int k = 0; k < 3; k++)
        nxt_h[k*ErrW +: ErrW] = ((col_q == '0) ? '0 : nxt_h[k*ErrW +: ErrW])
                                + div16(mulk(e_q[k], 13'sd5));
      w[rsel_n*HalfW +: HalfW] = nxt_h;
      wdata = w;
    end else if (cmd_i.wr_xp) begin
      we    = !last;
      waddr = col_q + CW'(1);
      w     = wxp_q;
      cur_h = w[rsel_q*HalfW +: HalfW];
      for (int k = 0; k < 3; k++) begin
        cur_h[k*ErrW +: ErrW] = cur_h[k*ErrW +: ErrW] + div16(mulk(e_q[k], 13'sd7));
        nxt_h[k*ErrW +: ErrW] = div16(13'(e_q[k]));
      end
      w[rsel_q*HalfW +: HalfW] = cur_h;
      w[rsel_n*HalfW +: HalfW] = nxt_h;
      wdata = w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) emem[waddr] <= wdata;
    if (re) erd_q <= emem[raddr];
  end

  assign pal_we = cmd_i.take && (in_data_i.command == CMD_PALETTE) &&
                  (32'(in_data_i.entry_index) < PALETTE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (pal_we)
      pmem[PA'(in_data_i.entry_index)] <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    if (cmd_i.srch_step) prd_q <= pmem[sa_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      col_q  <= '0;
      rsel_q <= 1'b0;
      pv_q   <= 1'b0;
      sa_q   <= '0;
    end else begin
      if (cmd_i.clr_en) clr_q <= stat_o.clr_done ? '0 : clr_q + CW'(1);
      if (cmd_i.take && in_data_i.command == CMD_PIXEL && in_data_i.frame_start) begin
        col_q  <= '0;
        rsel_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        if (last) begin
          col_q  <= '0;
          rsel_q <= ~rsel_q;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      pv_q <= cmd_i.srch_step;
      if (cmd_i.srch_start)     sa_q <= '0;
      else if (cmd_i.srch_step) sa_q <= sa_q + PA'(1);
    end
  end

  // shared distance unit
  assign dcur = dist_sq(c_q, prd_q);

  always_ff @(posedge clk_i) begin
    logic [HalfW-1:0]   ch;
    logic signed [10:0] s;
    ch = erd_q[rsel_q*HalfW +: HalfW];
    if (cmd_i.take) pix_q <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    if (cmd_i.cap_x) begin
      wx_q <= erd_q;
      for (int k = 0; k < 3; k++) begin
        s = $signed({3'b000, pix_q[(2-k)*8 +: 8]}) + 11'($signed(ch[k*ErrW +: ErrW]));
        if (s < 0)           c_q[(2-k)*8 +: 8] <= 8'd0;
        else if (s > 11'sd255) c_q[(2-k)*8 +: 8] <= 8'd255;
        else                 c_q[(2-k)*8 +: 8] <= s[7:0];
      end
    end
    if (cmd_i.cap_xm) wxm_q <= erd_q;
    if (cmd_i.cap_xp) wxp_q <= erd_q;
    if (cmd_i.srch_step) pi_q <= sa_q;
    if (pv_q && (pi_q == '0 || dcur < bestd_q)) begin
      bestd_q   <= dcur;
      best_q    <= pi_q;
      bestrgb_q <= prd_q;
    end
    if (cmd_i.calc_err)
      for (int k = 0; k < 3; k++)
        e_q[k] <= ErrW'($signed({2'b00, c_q[(2-k)*8 +: 8]}) -
                        $signed({2'b00, bestrgb_q[(2-k)*8 +: 8]}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.color_index <= 8'(best_q);
      out_q.row_end     <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[sv/floyd_steinberg_palette_dither.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// floyd_steinberg_palette_dither
// Error-diffusion dither of raster RGB pixels onto a loaded palette.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): palette loads and pixels. A palette
// load gives no result. A pixel gives one transaction on the output channel
// (out_valid_o / out_stall_i) with its palette index and an end-of-row flag.
// The palette search reads one entry per cycle through a single distance unit.
// A new item is accepted only after the previous pixel has been emitted. A
// frame-start pixel first sweeps the error-row memory. After reset the same
// sweep runs while in_stall_o stays high; configuration writes are taken
// throughout. The result sits in an output register; a new item is accepted
// while it waits. If the receiver stalls, the next pixel's result waits until
// that register drains. Configuration (image_width, palette_count) is written
// via cfg_we_i.
// ----------------------------------------------------------------------------
module floyd_steinberg_palette_dither #(
  parameter int MAX_WIDTH     = fsd_pkg::MaxWidthDef,
  parameter int PALETTE_DEPTH = fsd_pkg::PaletteDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [fsd_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  fsd_pkg::pix_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output fsd_pkg::pix_out_t        out_data_o
);
  import fsd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fsd_dp #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire
